@@ rtl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion to Euler angles
// Word widths, the singular case codes, the lane structs passed between
// the CORDIC cells and the arctangent table.
// ----------------------------------------------------------------------------
package qte_pkg;

    // widths of the arithmetic words
    localparam int Q_W   = 16;  // Q1.14 quaternion component
    localparam int OP_W  = 35;  // atan2 operands, exact Q.28 sums
    localparam int T_W   = 30;  // clamped test value, Q.28
    localparam int R_W   = 57;  // square root radicand and partial root
    localparam int C_W   = 29;  // final square root
    localparam int CW    = 45;  // CORDIC x/y lane
    localparam int ZW    = 36;  // CORDIC angle, Q.30
    localparam int MW    = 41;  // normalization magnitude
    localparam int TAB_LEN    = 24;
    localparam int NORM_STEPS = 6;
    localparam int SQ_N       = 29;

    localparam logic signed [ZW-1:0] PI_Q30    = 36'sd3373259426;
    localparam logic signed [OP_W-1:0] THRESH  = 35'sd268435188;
    localparam logic signed [T_W-1:0] ONE_Q28  = 30'sd268435456;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

    typedef enum logic [1:0] {
        SING_NONE = 2'd0,
        SING_POS  = 2'd1,
        SING_NEG  = 2'd2
    } t_sing;

    // one CORDIC lane position
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 bypass;
    } t_lane;

    // lane plus magnitude during normalization
    typedef struct packed {
        t_lane           lane;
        logic [MW-1:0]   m;
    } t_norm;

    // operands that ride beside the square root chain
    typedef struct packed {
        t_sing                  sing;
        logic signed [T_W-1:0]  t;
        logic signed [OP_W-1:0] roll_y;
        logic signed [OP_W-1:0] roll_x;
        logic signed [OP_W-1:0] yaw_y;
        logic signed [OP_W-1:0] yaw_x;
    } t_side;

    // atan(2^-i) in Q.30, truncated
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/quat_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quat_to_euler_angles: unit quaternion to yaw, pitch and roll
// Takes Q1.14 quaternions (x,y,z,w) and returns Q3.13 radian angles plus a
// singular pose code. Fully pipelined: one request per cycle while the output
// is not held; the 29-step square root chain for pitch and the CORDIC cell
// rows set the depth.
// ----------------------------------------------------------------------------
module quat_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // yaw_angle[15:0], pitch_angle[30:16], roll_angle[47:31]
    output logic [47:0] o_m_axis_tdata,
    // singular_case[1:0]
    output logic [1:0]  o_m_axis_tuser
);
    localparam int NS       = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int LANE_LAT = 1 + NORM_STEPS + NS;
    localparam int PIPE     = 3 + SQ_N + LANE_LAT;

    logic adv;
    logic [PIPE-1:0] r_vld;
    logic            r_out_valid;

    logic signed [Q_W-1:0] qx, qy, qz, qw;  // remapped X, Y, Z, W
    logic signed [Q_W-1:0] r_qx, r_qw;
    logic signed [31:0] r_yw, r_xz, r_xy, r_zw, r_yz, r_xw;
    logic signed [31:0] r_sx, r_sy, r_sz, r_sw;

    logic signed [OP_W-1:0] test;
    t_side                  n_side, r_side2, r_side3;
    logic [T_W-2:0]         t_abs;
    logic [R_W-1:0]         r_rad;
    t_side                  side_d [SQ_N];
    logic [R_W-1:0]         sq_rem [SQ_N+1];
    logic [R_W-1:0]         sq_res [SQ_N+1];
    t_sing                  sing_d [LANE_LAT];
    t_side                  side_q;

    logic signed [ZW-1:0] z_roll, z_yaw, z_pitch;
    logic signed [17:0]   q_roll, q_yaw, q_pitch;
    logic signed [16:0]   n_roll, r_roll;
    logic signed [15:0]   n_yaw, r_yaw;
    logic signed [14:0]   n_pitch, r_pitch;
    t_sing                r_sing;

    // advance the whole pipe unless the output is held
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[PIPE-2:0], i_s_axis_tvalid};
            r_out_valid <= r_vld[PIPE-1];
        end
    end

    // remap and form all products
    assign qy = i_s_axis_tdata[15:0];
    assign qx = i_s_axis_tdata[31:16];
    assign qz = i_s_axis_tdata[47:32];
    assign qw = i_s_axis_tdata[63:48];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yw <= qy * qw;
            r_xz <= qx * qz;
            r_xy <= qx * qy;
            r_zw <= qz * qw;
            r_yz <= qy * qz;
            r_xw <= qx * qw;
            r_sx <= qx * qx;
            r_sy <= qy * qy;
            r_sz <= qz * qz;
            r_sw <= qw * qw;
        end
    end

    // hold the remapped components one more stage for the singular roll
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qx <= qx;
            r_qw <= qw;
        end
    end

    // test value, singular decision and atan2 operands
    always_comb begin
        test = (OP_W'(r_yw) - OP_W'(r_xz)) <<< 1;
        if (test > THRESH) begin
            n_side.sing = SING_POS;
        end else if (test < -THRESH) begin
            n_side.sing = SING_NEG;
        end else begin
            n_side.sing = SING_NONE;
        end
        if (test > OP_W'(ONE_Q28)) begin
            n_side.t = ONE_Q28;
        end else if (test < -OP_W'(ONE_Q28)) begin
            n_side.t = -ONE_Q28;
        end else begin
            n_side.t = T_W'(test);
        end
        if (n_side.sing != SING_NONE) begin
            n_side.roll_y = OP_W'(r_qx);
            n_side.roll_x = OP_W'(r_qw);
        end else begin
            n_side.roll_y = (OP_W'(r_xy) + OP_W'(r_zw)) <<< 1;
            n_side.roll_x = OP_W'(r_sx) - OP_W'(r_sy) - OP_W'(r_sz) + OP_W'(r_sw);
        end
        n_side.yaw_y = (OP_W'(r_yz) + OP_W'(r_xw)) <<< 1;
        n_side.yaw_x = OP_W'(r_sz) + OP_W'(r_sw) - OP_W'(r_sx) - OP_W'(r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side2 <= n_side;
        end
    end

    // radicand 2^56 - t^2 for the pitch cosine
    assign t_abs = (r_side2.t < 0) ? (T_W-1)'(-r_side2.t) : (T_W-1)'(r_side2.t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad   <= R_W'((58'd1 << 56) - (58'(t_abs) * 58'(t_abs)));
            r_side3 <= r_side2;
        end
    end

    // square root cells, operands delayed alongside
    assign sq_rem[0] = r_rad;
    assign sq_res[0] = '0;

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        qte_sqrt_cell #(.K(SQ_N - 1 - j)) u_sqrt (
            .i_clk (i_clk),
            .i_ce  (adv),
            .i_rem (sq_rem[j]),
            .i_res (sq_res[j]),
            .o_rem (sq_rem[j+1]),
            .o_res (sq_res[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            side_d[0] <= r_side3;
            for (int k = 1; k < SQ_N; k++) begin
                side_d[k] <= side_d[k-1];
            end
        end
    end

    assign side_q = side_d[SQ_N-1];

    // three atan2 lanes
    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk (i_clk),
        .i_ce  (adv),
        .i_y   (side_q.roll_y),
        .i_x   (side_q.roll_x),
        .o_z   (z_roll)
    );

    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk (i_clk),
        .i_ce  (adv),
        .i_y   (side_q.yaw_y),
        .i_x   (side_q.yaw_x),
        .o_z   (z_yaw)
    );

    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk (i_clk),
        .i_ce  (adv),
        .i_y   (OP_W'(side_q.t)),
        .i_x   (OP_W'({1'b0, sq_res[SQ_N][C_W-1:0]})),
        .o_z   (z_pitch)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            sing_d[0] <= side_q.sing;
            for (int k = 1; k < LANE_LAT; k++) begin
                sing_d[k] <= sing_d[k-1];
            end
        end
    end

    // round to Q3.13 and saturate
    function automatic logic signed [17:0] to_q13(input logic signed [ZW-1:0] z,
                                                  input logic signed [17:0] lim);
        logic signed [ZW-1:0]  s;
        logic signed [ZW-18:0] r;
        s = (z + ZW'(65536)) >>> 17;
        r = (ZW-17)'(s);
        if (r > (ZW-17)'(lim)) begin
            return lim;
        end else if (r < -(ZW-17)'(lim)) begin
            return -lim;
        end
        return 18'(r);
    endfunction

    always_comb begin
        q_roll  = to_q13(z_roll, PI_Q13);
        q_yaw   = to_q13(z_yaw, PI_Q13);
        q_pitch = to_q13(z_pitch, HALF_PI_Q13);
        case (sing_d[LANE_LAT-1])
            SING_POS: begin
                n_roll  = 17'(-(q_roll <<< 1));
                n_yaw   = '0;
                n_pitch = 15'(HALF_PI_Q13);
            end
            SING_NEG: begin
                n_roll  = 17'(q_roll <<< 1);
                n_yaw   = '0;
                n_pitch = 15'(-HALF_PI_Q13);
            end
            default: begin
                n_roll  = 17'(q_roll);
                n_yaw   = 16'(q_yaw);
                n_pitch = 15'(q_pitch);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll  <= n_roll;
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
            r_sing  <= sing_d[LANE_LAT-1];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_roll, r_pitch, r_yaw};
    assign o_m_axis_tuser  = r_sing;

    // checks
    a_sing_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_sing != SING_NONE)) |-> (r_yaw == 16'sd0))
        else $error("yaw not zero in singular pose");

    a_sing_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_sing == SING_POS)) |-> (r_pitch == 15'(HALF_PI_Q13)))
        else $error("pitch not +pi/2 in singular pose");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_vld == $past(r_vld)))
        else $error("pipe moved while output held");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("bad singular code");
endmodule

@@ rtl/qte_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one digit step of the integer square root
// Tries one result bit against the remainder and hands the pair on.
// ----------------------------------------------------------------------------
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_ce,
    input  logic [R_W-1:0] i_rem,
    input  logic [R_W-1:0] i_res,
    output logic [R_W-1:0] o_rem,
    output logic [R_W-1:0] o_res
);
    localparam logic [R_W:0] BIT = (R_W+1)'(1) << (2 * K);

    logic [R_W:0]   sum;
    logic [R_W-1:0] n_rem, n_res;
    logic [R_W-1:0] r_rem, r_res;

    // subtract the trial value when it fits
    always_comb begin
        sum = {1'b0, i_res} + BIT;
        if ({1'b0, i_rem} >= sum) begin
            n_rem = R_W'({1'b0, i_rem} - sum);
            n_res = R_W'({2'b0, i_res[R_W-1:1]} + BIT);
        end else begin
            n_rem = i_rem;
            n_res = {1'b0, i_res[R_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;
endmodule

@@ rtl/qte_norm_cell.sv @@
// ----------------------------------------------------------------------------
// qte_norm_cell: one step of the operand normalization search
// Shifts the pair left by SH when the magnitude stays below 2^41.
// ----------------------------------------------------------------------------
module qte_norm_cell
    import qte_pkg::*;
#(
    parameter int SH = 1
) (
    input  logic  i_clk,
    input  logic  i_ce,
    input  t_norm i_d,
    output t_norm o_q
);
    localparam logic [MW:0] LIMIT = (MW+1)'(1) << (MW - SH);

    t_norm n_q, r_q;

    // shift the pair left by SH while it stays in range
    always_comb begin
        n_q = i_d;
        if (!i_d.lane.bypass && ({1'b0, i_d.m} < LIMIT)) begin
            n_q.lane.x = i_d.lane.x <<< SH;
            n_q.lane.y = i_d.lane.y <<< SH;
            n_q.m      = i_d.m << SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/qte_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward y = 0 and accumulates the table angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_ce,
    input  t_lane i_d,
    output t_lane o_q
);
    localparam logic signed [ZW-1:0] ANG = ZW'(signed'({1'b0, atan_entry(IDX)}));

    logic signed [CW-1:0] dx, dy;
    t_lane n_q, r_q;

    // rotate by +/- atan(2^-IDX)
    always_comb begin
        dx  = i_d.y >>> IDX;
        dy  = i_d.x >>> IDX;
        n_q = i_d;
        if (!i_d.bypass) begin
            if (i_d.y > 0) begin
                n_q.x = i_d.x + dx;
                n_q.y = i_d.y - dy;
                n_q.z = i_d.z + ANG;
            end else begin
                n_q.x = i_d.x - dx;
                n_q.y = i_d.y + dy;
                n_q.z = i_d.z - ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/qte_atan2.sv @@
// ----------------------------------------------------------------------------
// qte_atan2: pipelined atan2 lane
// Quadrant fold, six normalization cells, then a row of CORDIC cells.
// ----------------------------------------------------------------------------
module qte_atan2
    import qte_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_ce,
    input  logic signed [OP_W-1:0] i_y,
    input  logic signed [OP_W-1:0] i_x,
    output logic signed [ZW-1:0]   o_z
);
    localparam int NS = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;

    logic signed [CW-1:0] xe, ye, x1, y1, ay;
    logic                 neg;
    t_norm                n_prep, r_prep;
    t_norm                norm_d [NORM_STEPS+1];
    t_lane                cdc_d  [NS+1];

    // fold the left half plane and flag the trivial cases
    always_comb begin
        xe  = CW'(i_x);
        ye  = CW'(i_y);
        neg = (i_x < 0);
        x1  = neg ? -xe : xe;
        y1  = neg ? -ye : ye;
        ay  = (y1 < 0) ? -y1 : y1;
        n_prep.lane.x      = x1;
        n_prep.lane.y      = y1;
        n_prep.lane.z      = neg ? ((i_y >= 0) ? PI_Q30 : -PI_Q30) : '0;
        n_prep.lane.bypass = (y1 == 0);
        n_prep.m           = (x1 > ay) ? MW'(x1) : MW'(ay);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prep <= n_prep;
        end
    end

    assign norm_d[0] = r_prep;

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        qte_norm_cell #(.SH(32 >> j)) u_norm (
            .i_clk (i_clk),
            .i_ce  (i_ce),
            .i_d   (norm_d[j]),
            .o_q   (norm_d[j+1])
        );
    end

    assign cdc_d[0] = norm_d[NORM_STEPS].lane;

    for (genvar i = 0; i < NS; i++) begin : g_cdc
        qte_cordic_cell #(.IDX(i)) u_cdc (
            .i_clk (i_clk),
            .i_ce  (i_ce),
            .i_d   (cdc_d[i]),
            .o_q   (cdc_d[i+1])
        );
    end

    assign o_z = cdc_d[NS].z;
endmodule
